// ===== hdl/stsc_pkg.sv =====
// ----------------------------------------------------------------------------
// stsc_pkg
// Shared types and codes of the script token scanner: token kinds, field
// widths and the record that carries the tokens of one input byte.
// ----------------------------------------------------------------------------
`default_nettype none

package stsc_pkg;

    localparam int POS_W  = 16;
    localparam int LINE_W = 16;
    localparam int KIND_W = 5;
    localparam int CHAR_W = 8;

    // Token kinds
    localparam logic [KIND_W-1:0] K_EOF     = 5'd0;
    localparam logic [KIND_W-1:0] K_EOL     = 5'd1;
    localparam logic [KIND_W-1:0] K_NAME    = 5'd2;
    localparam logic [KIND_W-1:0] K_NUMBER  = 5'd3;
    localparam logic [KIND_W-1:0] K_KW_BASE = 5'd4;
    localparam logic [KIND_W-1:0] K_OP_BASE = 5'd16;
    localparam logic [KIND_W-1:0] K_SINGLE  = 5'd22;
    localparam logic [KIND_W-1:0] K_NUMERR  = 5'd23;

    // Tokens caused by one byte: an optional pending token (name, keyword,
    // number, operator or single char), an optional end-of-line or single
    // char, an optional end-of-file. All of them carry the same line number.
    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic              a_v;
        logic [KIND_W-1:0] a_kind;
        logic [CHAR_W-1:0] a_sym;
        logic [POS_W-1:0]  a_start;
        logic [POS_W-1:0]  a_len;
        logic              b_v;
        logic [KIND_W-1:0] b_kind;
        logic [CHAR_W-1:0] b_sym;
        logic              c_v;
    } bundle_t;

endpackage

`default_nettype wire

// ===== hdl/script_token_scanner.sv =====
// ----------------------------------------------------------------------------
// script_token_scanner
// Byte-stream lexer: turns source text into name, keyword, number, operator,
// symbol, end-of-line and end-of-file tokens.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (lowest bit up)                  | tuser     | tlast
//  s_      | in  | ch[7:0]                                | -         | -
//  m_      | out | sym_char[7:0] line_no[23:8]            | kind[4:0] | last
//          |     | start_pos[39:24] length[55:40]         |           |
//
//  The scanner takes one byte per cycle while the four-bundle queue has room.
//  Each byte yields zero to three tokens; the emitter sends one token per
//  cycle while m_tready is high.
//  A byte can enter in the cycle after it is accepted; the first token of a
//  byte is offered on m_ after the queue entry and the emitter's bundle register.
//  rst_n clears the scan state and empties the queue; no clearing pass.
//  m_tready low fills the queue, then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module script_token_scanner
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // ch[7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,    // sym_char, line_no, start_pos, length
    output logic [stsc_pkg::KIND_W-1:0] m_tuser,    // kind
    output logic             m_tlast
);
    import stsc_pkg::*;

    bundle_t             fe_bundle;
    logic                fe_bundle_v;
    logic                take;
    bundle_t             q_head;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;
    logic [CHAR_W-1:0]   sym_char;
    logic [LINE_W-1:0]   line_no;
    logic [POS_W-1:0]    start_pos;
    logic [POS_W-1:0]    length;

    assign s_tready = !q_full;
    assign take     = s_tvalid && s_tready;

    stsc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .ch       (s_tdata),
        .bundle   (fe_bundle),
        .bundle_v (fe_bundle_v)
    );

    stsc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && fe_bundle_v),
        .push_data (fe_bundle),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    stsc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .tok_valid (m_tvalid),
        .tok_ready (m_tready),
        .kind      (m_tuser),
        .sym_char  (sym_char),
        .line_no   (line_no),
        .start_pos (start_pos),
        .length    (length),
        .last      (m_tlast)
    );

    // Pack the token beat
    assign m_tdata = {length, start_pos, line_no, sym_char};

endmodule

`default_nettype wire

// ===== hdl/stsc_front.sv =====
// ----------------------------------------------------------------------------
// stsc_front
// Scanner front end: classifies one byte per beat, tracks the scan mode,
// position and line, and builds the tokens that the byte completes.
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             take,       // byte accepted this cycle
    input  wire logic [7:0]       ch,
    output stsc_pkg::bundle_t     bundle,
    output logic                  bundle_v    // bundle holds at least one token
);
    import stsc_pkg::*;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_WORD    = 3'd1;
    localparam logic [2:0] MODE_INT     = 3'd2;
    localparam logic [2:0] MODE_FRAC    = 3'd3;
    localparam logic [2:0] MODE_COMMENT = 3'd4;
    localparam logic [2:0] MODE_PREFIX  = 3'd5;

    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_prefix(input logic [7:0] c);
        return (c == "=") || (c == "!") || (c == "&") || (c == "|") ||
               (c == "<") || (c == ">");
    endfunction

    // Keyword lookup on the packed word; valid only with length 1..8
    function automatic logic [4:0] kw_lookup(input logic [63:0] w);
        logic [4:0] r;
        r = 5'd31;
        case (w)
            64'h0000_0000_006E_696C: r = 5'd0;   // nil
            64'h0000_0000_7472_7565: r = 5'd1;   // true
            64'h0000_0066_616C_7365: r = 5'd2;   // false
            64'h0000_0000_6675_6E63: r = 5'd3;   // func
            64'h0000_0000_0076_6172: r = 5'd4;   // var
            64'h0000_0000_0000_6966: r = 5'd5;   // if
            64'h0000_0000_656C_7365: r = 5'd6;   // else
            64'h0000_0077_6869_6C65: r = 5'd7;   // while
            64'h0000_0070_7269_6E74: r = 5'd8;   // print
            64'h0000_0062_7265_616B: r = 5'd9;   // break
            64'h636F_6E74_696E_7565: r = 5'd10;  // continue
            64'h0000_7265_7475_726E: r = 5'd11;  // return
            default:                 r = 5'd31;
        endcase
        return r;
    endfunction

    logic [2:0]        mode_reg,   mode_next;
    logic [7:0]        prefix_reg, prefix_next;
    logic [63:0]       word_reg,   word_next;
    logic [POS_W-1:0]  start_reg,  start_next;
    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [LINE_W-1:0] line_reg,   line_next;
    logic              nlsp_reg,   nlsp_next;

    logic [POS_W-1:0]  tok_len;
    logic [4:0]        kw_idx;
    logic              kw_hit;
    logic [7:0]        second_ch;
    logic [2:0]        op_idx;
    logic              done;

    assign tok_len = pos_reg - start_reg;
    assign kw_idx  = kw_lookup(word_reg);
    assign kw_hit  = (tok_len >= POS_W'(1)) && (tok_len <= POS_W'(8)) && (kw_idx != 5'd31);

    // Second char and operator slot of the held prefix
    always_comb
    begin
        second_ch = "=";
        op_idx    = 3'd0;
        case (prefix_reg)
            "=":     begin second_ch = "="; op_idx = 3'd0; end
            "!":     begin second_ch = "="; op_idx = 3'd1; end
            "&":     begin second_ch = "&"; op_idx = 3'd2; end
            "|":     begin second_ch = "|"; op_idx = 3'd3; end
            "<":     begin second_ch = "="; op_idx = 3'd4; end
            ">":     begin second_ch = "="; op_idx = 3'd5; end
            default: begin second_ch = 8'd0; op_idx = 3'd0; end
        endcase
    end

    // Scan one byte
    always_comb
    begin
        mode_next   = mode_reg;
        prefix_next = prefix_reg;
        word_next   = word_reg;
        start_next  = start_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        nlsp_next   = nlsp_reg;
        done        = 1'b0;

        bundle         = '0;
        bundle.line    = line_reg;
        bundle.b_kind  = K_EOL;

        // Finish or extend the pending token
        case (mode_reg)
            MODE_WORD:
            begin
                if (is_word_start(ch) || is_digit(ch))
                begin
                    word_next = {word_reg[55:0], ch};
                    pos_next  = pos_reg + POS_W'(1);
                    done      = 1'b1;
                end
                else
                begin
                    bundle.a_v = 1'b1;
                    if (kw_hit)
                    begin
                        bundle.a_kind = K_KW_BASE + kw_idx;
                        nlsp_next     = (kw_idx < 5'd9);
                    end
                    else
                    begin
                        bundle.a_kind  = K_NAME;
                        bundle.a_start = start_reg;
                        bundle.a_len   = tok_len;
                        nlsp_next      = 1'b0;
                    end
                    mode_next = MODE_IDLE;
                end
            end
            MODE_INT, MODE_FRAC:
            begin
                if (is_digit(ch) || ((ch == ".") && (mode_reg == MODE_INT)))
                begin
                    if (ch == ".")
                        mode_next = MODE_FRAC;
                    pos_next = pos_reg + POS_W'(1);
                    done     = 1'b1;
                end
                else
                begin
                    bundle.a_v     = 1'b1;
                    bundle.a_kind  = is_word_start(ch) ? K_NUMERR : K_NUMBER;
                    bundle.a_start = start_reg;
                    bundle.a_len   = tok_len;
                    nlsp_next      = 1'b0;
                    mode_next      = MODE_IDLE;
                end
            end
            MODE_COMMENT:
            begin
                if ((ch != "\n") && (ch != 8'd0))
                begin
                    pos_next = pos_reg + POS_W'(1);
                    done     = 1'b1;
                end
                else
                    mode_next = MODE_IDLE;
            end
            MODE_PREFIX:
            begin
                mode_next  = MODE_IDLE;
                nlsp_next  = 1'b1;
                bundle.a_v = 1'b1;
                if (ch == second_ch)
                begin
                    bundle.a_kind = K_OP_BASE + KIND_W'(op_idx);
                    pos_next      = pos_reg + POS_W'(1);
                    done          = 1'b1;
                end
                else
                begin
                    bundle.a_kind = K_SINGLE;
                    bundle.a_sym  = prefix_reg;
                end
            end
            default:
                mode_next = MODE_IDLE;
        endcase

        // Classify the byte itself
        if (!done)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (ch == 8'd0)
            begin
                bundle.b_v  = !nlsp_next;
                bundle.c_v  = 1'b1;
                mode_next   = MODE_IDLE;
                prefix_next = 8'd0;
                word_next   = 64'd0;
                start_next  = '0;
                pos_next    = '0;
                line_next   = '0;
                nlsp_next   = 1'b1;
            end
            else if ((ch == " ") || (ch == "\t") || (ch == "\r"))
            begin
                // blank: drop
            end
            else if (ch == "\n")
            begin
                if (!nlsp_next)
                begin
                    bundle.b_v = 1'b1;
                    nlsp_next  = 1'b1;
                end
                if (line_reg != LINE_MAX)
                    line_next = line_reg + LINE_W'(1);
            end
            else if (ch == "#")
                mode_next = MODE_COMMENT;
            else if (is_word_start(ch))
            begin
                mode_next  = MODE_WORD;
                start_next = pos_reg;
                word_next  = {56'd0, ch};
            end
            else if (is_digit(ch))
            begin
                mode_next  = MODE_INT;
                start_next = pos_reg;
            end
            else if (is_prefix(ch))
            begin
                mode_next   = MODE_PREFIX;
                prefix_next = ch;
            end
            else
            begin
                bundle.b_v    = 1'b1;
                bundle.b_kind = K_SINGLE;
                bundle.b_sym  = ch;
                nlsp_next     = !((ch == ")") || (ch == "]") || (ch == "}"));
            end
        end

        bundle_v = bundle.a_v || bundle.b_v || bundle.c_v;
    end

    // Advance scan state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            prefix_reg <= 8'd0;
            word_reg   <= 64'd0;
            start_reg  <= '0;
            pos_reg    <= '0;
            line_reg   <= '0;
            nlsp_reg   <= 1'b1;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            prefix_reg <= prefix_next;
            word_reg   <= word_next;
            start_reg  <= start_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            nlsp_reg   <= nlsp_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/stsc_queue.sv =====
// ----------------------------------------------------------------------------
// stsc_queue
// Four-entry register queue of token bundles between scanner and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire stsc_pkg::bundle_t push_data,
    input  wire logic              pop,
    output stsc_pkg::bundle_t      head,
    output logic                   full,
    output logic                   empty
);
    import stsc_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    bundle_t           mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;

    assign full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // Store a bundle at the tail
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (PTR_W+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PTR_W+1)'(1);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/stsc_back.sv =====
// ----------------------------------------------------------------------------
// stsc_back
// Token emitter: holds one bundle and sends its tokens one beat at a time,
// marking the final token of the bundle with last.
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_back
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire stsc_pkg::bundle_t         head,
    input  wire logic                      empty,
    output logic                           pop,
    output logic                           tok_valid,
    input  wire logic                      tok_ready,
    output logic [stsc_pkg::KIND_W-1:0]    kind,
    output logic [stsc_pkg::CHAR_W-1:0]    sym_char,
    output logic [stsc_pkg::LINE_W-1:0]    line_no,
    output logic [stsc_pkg::POS_W-1:0]     start_pos,
    output logic [stsc_pkg::POS_W-1:0]     length,
    output logic                           last
);
    import stsc_pkg::*;

    bundle_t    cur_reg;
    logic [2:0] pend_reg, pend_next;
    logic [2:0] pend_after;
    logic [2:0] pend_rest;
    logic       sent;

    assign pend_rest  = pend_reg & (pend_reg - 3'd1);
    assign sent       = tok_valid && tok_ready;
    assign pend_after = sent ? pend_rest : pend_reg;
    assign pop        = (pend_after == 3'd0) && !empty;
    assign pend_next  = pop ? {head.c_v, head.b_v, head.a_v} : pend_after;

    // Select the first pending token
    always_comb
    begin
        tok_valid = (pend_reg != 3'd0);
        last      = (pend_rest == 3'd0);
        line_no   = cur_reg.line;
        kind      = K_EOF;
        sym_char  = '0;
        start_pos = '0;
        length    = '0;
        if (pend_reg[0])
        begin
            kind      = cur_reg.a_kind;
            sym_char  = cur_reg.a_sym;
            start_pos = cur_reg.a_start;
            length    = cur_reg.a_len;
        end
        else if (pend_reg[1])
        begin
            kind     = cur_reg.b_kind;
            sym_char = cur_reg.b_sym;
        end
    end

    // Hold the current bundle
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 3'd0;
        else
            pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

// ===== hdl/stsc_checker.sv =====
// ----------------------------------------------------------------------------
// stsc_checker
// Port-level checks of the token scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [stsc_pkg::KIND_W-1:0] m_tuser,
    input wire logic        m_tlast
);
    import stsc_pkg::*;

    logic [KIND_W-1:0] kind;
    assign kind = m_tuser;

    // Stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled token beat changed");

    // End-of-file always closes its byte
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (kind == K_EOF) |-> m_tlast)
        else $error("end-of-file without last");

    // Kind stays in range
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (kind <= K_NUMERR))
        else $error("bad token kind");

    // Only names and numbers carry offsets
    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (kind != K_NAME) && (kind != K_NUMBER) && (kind != K_NUMERR)
        |-> (m_tdata[55:24] == 32'd0))
        else $error("offset on a token without span");

endmodule

bind script_token_scanner stsc_checker u_stsc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
